// File: hw/rtl/flat_page_table_iommu_top_defines.svh
// Assertion macros shared by the page table controller and datapath.
`ifndef FLAT_PAGE_TABLE_IOMMU_TOP_DEFINES_SVH
`define FLAT_PAGE_TABLE_IOMMU_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FPT_ASSERT_SAME(lbl, ante, cons, msg)
`define FPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/fpt_pkg.sv
// Types, codes and sizes shared by the flat page table IOMMU modules.
package fpt_pkg;

    localparam int TABLE_ENTRIES = 65536;
    localparam int PAGE_BITS     = 12;
    localparam int VA_W          = 32;
    localparam int VPN_W         = VA_W - PAGE_BITS;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int LIM_W         = VPN_W + 1;
    localparam logic [LIM_W-1:0] TABLE_LIMIT = LIM_W'(TABLE_ENTRIES);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACHED  = CFG_IDX_W'(2);
    localparam logic [VA_W-1:0]      WIN_END_RESET = 32'h0FFF_FFFF;

    localparam int IN_TDATA_W    = 104;
    localparam int OUT_FIELDS_W  = 34;
    localparam int OUT_TDATA_W   = 40;

    typedef enum logic [1:0] {
        ACT_MAP   = 2'd0,
        ACT_UNMAP = 2'd1,
        ACT_XLATE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_NODEV = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK,
        S_EVAL,
        S_WALK,
        S_READ,
        S_RDATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic check;
        logic eval;
        logic walk;
        logic read;
        logic compose;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic go_walk;
        logic go_read;
        logic walk_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hw/rtl/fpt_dp.sv
// Datapath: window checks, page table memory, walk counters and result register.
`include "flat_page_table_iommu_top_defines.svh"
module fpt_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fpt_pkg::t_dp_cmd               i_cmd,
    output fpt_pkg::t_dp_sts               o_sts,
    input  logic                           i_cfg_we,
    input  logic [fpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]                     i_action,
    input  logic [fpt_pkg::VA_W-1:0]       i_virt_addr,
    input  logic [fpt_pkg::VA_W-1:0]       i_phys_addr,
    input  logic [fpt_pkg::VA_W-1:0]       i_length_bytes,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [1:0]                     o_status,
    output logic [fpt_pkg::VA_W-1:0]       o_phys_out
);

    // configuration
    logic [fpt_pkg::VA_W-1:0] r_win_start;
    logic [fpt_pkg::VA_W-1:0] r_win_end;
    logic                     r_attached;

    // captured request
    fpt_pkg::t_action         r_action;
    logic [fpt_pkg::VA_W-1:0] r_va;
    logic [fpt_pkg::VA_W-1:0] r_pa;
    logic [fpt_pkg::VA_W-1:0] r_len;

    // check results
    logic                         r_lo_bad;
    logic                         r_span_bad;
    logic                         r_pt_bad;
    logic [fpt_pkg::VPN_W-1:0]    r_vpn;
    logic [fpt_pkg::PAGE_BITS-1:0] r_off_lo;
    logic [fpt_pkg::VPN_W-1:0]    r_pages;

    // walk state and result
    logic [fpt_pkg::IDX_W-1:0] r_idx;
    logic [fpt_pkg::CNT_W-1:0] r_left;
    logic [fpt_pkg::VPN_W-1:0] r_ppn;
    logic                      r_is_map;
    fpt_pkg::t_status          r_status;
    logic [fpt_pkg::VA_W-1:0]  r_phys;

    // table and its clearing sweep
    logic [fpt_pkg::VPN_W-1:0] r_table [fpt_pkg::TABLE_ENTRIES];
    logic [fpt_pkg::VPN_W-1:0] r_rdata;
    logic [fpt_pkg::IDX_W-1:0] r_clr_idx;

    // output register
    logic                     r_out_valid;
    fpt_pkg::t_status         r_out_status;
    logic [fpt_pkg::VA_W-1:0] r_out_phys;

    logic [fpt_pkg::VA_W:0]    w_span_end;
    logic [fpt_pkg::VA_W:0]    w_win_end_p1;
    logic [fpt_pkg::VA_W-1:0]  w_off;
    logic [fpt_pkg::LIM_W-1:0] w_span_last;
    logic                      w_tbl_span_bad;
    logic                      w_tbl_pt_bad;
    fpt_pkg::t_status          n_status;
    logic                      w_mem_we;
    logic [fpt_pkg::IDX_W-1:0] w_mem_addr;
    logic [fpt_pkg::VPN_W-1:0] w_mem_wdata;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_end   <= fpt_pkg::WIN_END_RESET;
            r_attached  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpt_pkg::CFG_WIN_START: r_win_start <= i_cfg_data;
                fpt_pkg::CFG_WIN_END:   r_win_end   <= i_cfg_data;
                fpt_pkg::CFG_ATTACHED:  r_attached  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // window bounds and offsets
    assign w_span_end   = {1'b0, r_va} + {1'b0, r_len};
    assign w_win_end_p1 = {1'b0, r_win_end} + (fpt_pkg::VA_W+1)'(1);
    assign w_off        = r_va - r_win_start;

    // table bounds on the registered page numbers
    assign w_span_last    = {1'b0, r_vpn} + {1'b0, r_pages};
    assign w_tbl_span_bad = w_span_last > fpt_pkg::TABLE_LIMIT;
    assign w_tbl_pt_bad   = {1'b0, r_vpn} >= fpt_pkg::TABLE_LIMIT;

    // decide the result status
    always_comb begin
        n_status = fpt_pkg::ST_OK;
        case (r_action)
            fpt_pkg::ACT_MAP: begin
                if (!r_attached) begin
                    n_status = fpt_pkg::ST_NODEV;
                end else if (r_lo_bad || r_span_bad || w_tbl_span_bad) begin
                    n_status = fpt_pkg::ST_RANGE;
                end
            end
            fpt_pkg::ACT_UNMAP: begin
                if (r_lo_bad || r_span_bad || w_tbl_span_bad) begin
                    n_status = fpt_pkg::ST_RANGE;
                end
            end
            fpt_pkg::ACT_XLATE: begin
                if (r_lo_bad || r_pt_bad || w_tbl_pt_bad) begin
                    n_status = fpt_pkg::ST_RANGE;
                end
            end
            default: n_status = fpt_pkg::ST_OK;
        endcase
    end

    // capture, check, evaluate, walk and compose
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= fpt_pkg::t_action'(i_action);
            r_va     <= i_virt_addr;
            r_pa     <= i_phys_addr;
            r_len    <= i_length_bytes;
        end
        if (i_cmd.check) begin
            r_lo_bad   <= r_va < r_win_start;
            r_span_bad <= w_span_end > w_win_end_p1;
            r_pt_bad   <= r_va > r_win_end;
            r_vpn      <= w_off[fpt_pkg::VA_W-1:fpt_pkg::PAGE_BITS];
            r_off_lo   <= w_off[fpt_pkg::PAGE_BITS-1:0];
            r_pages    <= r_len[fpt_pkg::VA_W-1:fpt_pkg::PAGE_BITS];
        end
        if (i_cmd.eval) begin
            r_status <= n_status;
            r_phys   <= '0;
            r_idx    <= fpt_pkg::IDX_W'(r_vpn);
            r_left   <= fpt_pkg::CNT_W'(r_pages);
            r_ppn    <= r_pa[fpt_pkg::VA_W-1:fpt_pkg::PAGE_BITS];
            r_is_map <= (r_action == fpt_pkg::ACT_MAP);
        end
        if (i_cmd.walk) begin
            r_idx  <= r_idx + fpt_pkg::IDX_W'(1);
            r_left <= r_left - fpt_pkg::CNT_W'(1);
            r_ppn  <= r_ppn + fpt_pkg::VPN_W'(1);
        end
        if (i_cmd.compose) begin
            r_phys <= {r_rdata, r_off_lo};
        end
    end

    // advance the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + fpt_pkg::IDX_W'(1);
        end
    end

    // one write port shared by the sweep and the walk
    assign w_mem_we    = i_cmd.clear || i_cmd.walk;
    assign w_mem_addr  = i_cmd.clear ? r_clr_idx : r_idx;
    assign w_mem_wdata = (i_cmd.walk && r_is_map) ? r_ppn : '0;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_table[w_mem_addr] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rdata <= r_table[r_idx];
        end
    end

    // hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_status <= r_status;
            r_out_phys   <= r_phys;
        end
    end

    // status back to the controller
    always_comb begin
        o_sts.clear_last = (r_clr_idx == fpt_pkg::IDX_W'(fpt_pkg::TABLE_ENTRIES - 1));
        o_sts.go_walk    = ((r_action == fpt_pkg::ACT_MAP) || (r_action == fpt_pkg::ACT_UNMAP))
                           && (n_status == fpt_pkg::ST_OK) && (r_pages != '0);
        o_sts.go_read    = (r_action == fpt_pkg::ACT_XLATE) && (n_status == fpt_pkg::ST_OK);
        o_sts.walk_last  = (r_left == fpt_pkg::CNT_W'(1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_phys_out  = r_out_phys;

    `FPT_ASSERT_SAME(a_walk_left, i_cmd.walk, r_left != '0, "walk with no pages left")
    `FPT_ASSERT_SAME(a_push_free, i_cmd.push, !r_out_valid || i_out_ready, "result overrun")
    `FPT_ASSERT_SAME(a_read_ok, i_cmd.read, r_status == fpt_pkg::ST_OK, "read on failed request")

endmodule

// File: hw/rtl/fpt_ctrl.sv
// Controller: sequences clearing, checks, table walk, lookup and result hand-off.
`include "flat_page_table_iommu_top_defines.svh"
module fpt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output fpt_pkg::t_dp_cmd o_cmd,
    input  fpt_pkg::t_dp_sts i_sts
);

    fpt_pkg::t_state r_state;
    fpt_pkg::t_state n_state;

    // state register; sweep the table after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            fpt_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = fpt_pkg::S_IDLE;
                end
            end
            fpt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = fpt_pkg::S_CHK;
                end
            end
            fpt_pkg::S_CHK: begin
                o_cmd.check = 1'b1;
                n_state     = fpt_pkg::S_EVAL;
            end
            fpt_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.go_walk) begin
                    n_state = fpt_pkg::S_WALK;
                end else if (i_sts.go_read) begin
                    n_state = fpt_pkg::S_READ;
                end else begin
                    n_state = fpt_pkg::S_DONE;
                end
            end
            fpt_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = fpt_pkg::S_DONE;
                end
            end
            fpt_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = fpt_pkg::S_RDATA;
            end
            fpt_pkg::S_RDATA: begin
                o_cmd.compose = 1'b1;
                n_state       = fpt_pkg::S_DONE;
            end
            fpt_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = fpt_pkg::S_IDLE;
                end
            end
            default: n_state = fpt_pkg::S_IDLE;
        endcase
    end

    `FPT_ASSERT_NEXT(a_read_compose, r_state == fpt_pkg::S_READ, r_state == fpt_pkg::S_RDATA, "lookup skipped compose")
    `FPT_ASSERT_SAME(a_eval_excl, r_state == fpt_pkg::S_EVAL, !(i_sts.go_walk && i_sts.go_read), "walk and read both chosen")
    `FPT_ASSERT_NEXT(a_walk_exit, (r_state == fpt_pkg::S_WALK) && i_sts.walk_last, r_state == fpt_pkg::S_DONE, "walk overran last page")

endmodule

// File: hw/rtl/flat_page_table_iommu_top.sv
// Top level of the flat page table IOMMU: stream ports, config port, controller and datapath.
//
// Requests enter on the s_axis channel (map, unmap or translate), one result leaves on
// m_axis for each request. Registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data: 0 window start, 1 window end (inclusive), 2 device attached flag.
// After reset the block sweeps the 65536-entry page table to zero, one entry per cycle;
// s_axis_tready stays low during the sweep, config writes are taken throughout.
// An accepted request passes check and evaluate; then a translate reads the table and composes
// its address, a map or unmap of N pages walks N entries, and a refused request or one under a page goes to done.
// The table memory has one write port, so the walk writes one entry per cycle and sets
// the length of map and unmap. Requests are handled one at a time; the next request is
// accepted the cycle after a result enters the output register.
// The output register holds a finished result while m_axis_tready is low; the block
// takes the next request meanwhile and waits only when its own result is ready and the
// output register is still full.
module flat_page_table_iommu_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // action[1:0], virt_addr[33:2], phys_addr[65:34], length_bytes[97:66], zero fill
    input  logic [fpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[1:0], phys_out[33:2], zero fill
    output logic [fpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [fpt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fpt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    fpt_pkg::t_dp_cmd         w_cmd;
    fpt_pkg::t_dp_sts         w_sts;
    logic [1:0]               w_status;
    logic [fpt_pkg::VA_W-1:0] w_phys;

    fpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    fpt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_action       (s_axis_tdata[1:0]),
        .i_virt_addr    (s_axis_tdata[33:2]),
        .i_phys_addr    (s_axis_tdata[65:34]),
        .i_length_bytes (s_axis_tdata[97:66]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_status       (w_status),
        .o_phys_out     (w_phys)
    );

    // pack the result fields, lowest field first
    assign m_axis_tdata = {{(fpt_pkg::OUT_TDATA_W - fpt_pkg::OUT_FIELDS_W){1'b0}},
                           w_phys, w_status};

endmodule

// File: tb/sv/flat_page_table_iommu_top_test.sv
// Self-checking stream testbench for the flat page table IOMMU top level.
module flat_page_table_iommu_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]      ACT_SPARE      = 2'd3;
    localparam longint unsigned PAGE_SIZE      = 64'd1 << fpt_pkg::PAGE_BITS;
    localparam longint unsigned HOT_PAGES      = 512;
    localparam int              RANDOM_PER_RUN = 250;
    localparam int              HOLD_CYCLES    = 400;
    localparam int              WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] va;
        logic [31:0] pa;
        logic [31:0] len;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] phys;
    } t_rsp;

    logic                                i_clk;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // action[1:0], virt_addr[33:2], phys_addr[65:34], length_bytes[97:66], zero fill
    logic [fpt_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // status[1:0], phys_out[33:2], zero fill
    logic [fpt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                i_cfg_we      = 1'b0;
    logic [fpt_pkg::CFG_IDX_W-1:0]       i_cfg_idx     = fpt_pkg::CFG_WIN_START;
    logic [fpt_pkg::CFG_DATA_W-1:0]      i_cfg_data    = '0;

    // Mirror of the block: page table and registers
    bit   [19:0] ppn_table [fpt_pkg::TABLE_ENTRIES];
    logic [31:0] win_lo   = 32'd0;
    logic [31:0] win_hi   = fpt_pkg::WIN_END_RESET;
    logic        attached = 1'b0;

    t_req req_fifo[$];
    t_rsp results_due[$];
    t_rsp due;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_armed     = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_cnt       = 0;
    int   idle_cycles    = 0;
    int   mismatch_count = 0;

    flat_page_table_iommu_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one request to the mirrored table and return the result it must give
    function automatic t_rsp service_request(t_req r);
        t_rsp            res;
        longint unsigned s, e, va, len, first, cnt, off, idx, k;
        logic [19:0]     ppn;
        res.status = fpt_pkg::ST_OK;
        res.phys   = '0;
        s   = win_lo;
        e   = win_hi;
        va  = r.va;
        len = r.len;
        case (r.action) inside
            fpt_pkg::ACT_MAP, fpt_pkg::ACT_UNMAP: begin
                // device check comes before the window check, and only for map
                if (r.action == fpt_pkg::ACT_MAP && !attached) begin
                    res.status = fpt_pkg::ST_NODEV;
                end else if (va < s || va + len > e + 1) begin
                    res.status = fpt_pkg::ST_RANGE;
                end else begin
                    first = (va - s) >> fpt_pkg::PAGE_BITS;
                    cnt   = len >> fpt_pkg::PAGE_BITS;
                    if (first + cnt > fpt_pkg::TABLE_ENTRIES) begin
                        res.status = fpt_pkg::ST_RANGE;
                    end else begin
                        ppn = r.pa[31:fpt_pkg::PAGE_BITS];
                        for (k = 0; k < cnt; k++) begin
                            ppn_table[first + k] = (r.action == fpt_pkg::ACT_MAP) ? ppn : 20'd0;
                            ppn = ppn + 20'd1;
                        end
                    end
                end
            end
            fpt_pkg::ACT_XLATE: begin
                if (va < s || va > e) begin
                    res.status = fpt_pkg::ST_RANGE;
                end else begin
                    off = va - s;
                    idx = off >> fpt_pkg::PAGE_BITS;
                    if (idx >= fpt_pkg::TABLE_ENTRIES) begin
                        res.status = fpt_pkg::ST_RANGE;
                    end else begin
                        res.phys = (32'(ppn_table[idx]) << fpt_pkg::PAGE_BITS)
                                 + 32'(off[fpt_pkg::PAGE_BITS-1:0]);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Request driver: hold an offered request until taken, then predict its result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(service_request(req_fifo.pop_front()));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'd0, req_fifo[0].len, req_fifo[0].pa,
                                      req_fifo[0].va, req_fifo[0].action};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls, with one long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
            hold_done     <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with no request outstanding: status %0d phys %h",
                             $time, m_axis_tdata[1:0], m_axis_tdata[33:2]);
                    mismatch_count++;
                end else begin
                    due = results_due.pop_front();
                    if (m_axis_tdata[1:0] !== due.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, due.status, m_axis_tdata[1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[33:2] !== due.phys) begin
                        $display("%0t: phys_out mismatch: expected %h actual %h",
                                 $time, due.phys, m_axis_tdata[33:2]);
                        mismatch_count++;
                    end
                end
            end
            if (hold_armed && !hold_done) begin
                m_axis_tready <= 1'b0;
                hold_cnt      <= hold_cnt + 1;
                if (hold_cnt == HOLD_CYCLES - 1) begin
                    hold_done <= 1'b1;
                end
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run after too long without any request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [fpt_pkg::CFG_IDX_W-1:0] idx,
                             logic [fpt_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            fpt_pkg::CFG_WIN_START: win_lo   = data;
            fpt_pkg::CFG_WIN_END:   win_hi   = data;
            fpt_pkg::CFG_ATTACHED:  attached = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_window(logic [31:0] lo, logic [31:0] hi, logic att);
        write_reg(fpt_pkg::CFG_WIN_START, lo);
        write_reg(fpt_pkg::CFG_WIN_END, hi);
        write_reg(fpt_pkg::CFG_ATTACHED, {31'd0, att});
    endtask

    task automatic queue_req(logic [1:0] action, logic [31:0] va, logic [31:0] pa,
                             logic [31:0] len);
        t_req r;
        r.action = action;
        r.va     = va;
        r.pa     = pa;
        r.len    = len;
        req_fifo.push_back(r);
    endtask

    // Wait until every request is taken and every result has come back
    task automatic drain();
        while (req_fifo.size() != 0 || results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random requests aimed mostly at a hot region at the bottom of the window
    task automatic queue_random(int n);
        t_req            r;
        longint unsigned lo64, hi64, span, hot, p, cnt, roll, sz;
        int              i;
        lo64 = win_lo;
        hi64 = win_hi;
        span = (hi64 >= lo64) ? ((hi64 - lo64 + 1) >> fpt_pkg::PAGE_BITS) : 0;
        if (span > fpt_pkg::TABLE_ENTRIES) span = fpt_pkg::TABLE_ENTRIES;
        hot = (span > HOT_PAGES) ? HOT_PAGES : span;
        for (i = 0; i < n; i++) begin
            roll  = $urandom_range(99);
            p     = (hot > 0) ? $urandom_range(32'(hot - 1)) : 0;
            r.pa  = $urandom;
            r.va  = 32'(lo64 + (p << fpt_pkg::PAGE_BITS));
            r.len = '0;
            if (roll < 6 || hot == 0) begin
                // noise over the whole field range
                r.action = 2'($urandom_range(3));
                r.va     = $urandom;
                r.len    = $urandom;
            end else if (roll < 10) begin
                // just outside either end of the window
                r.action = 2'($urandom_range(2));
                r.va     = $urandom_range(1) ? 32'(lo64 - 1 - $urandom_range(8191))
                                             : 32'(hi64 + 1 + $urandom_range(8191));
                r.len    = 32'($urandom_range(3)) << fpt_pkg::PAGE_BITS;
            end else if (roll < 60) begin
                r.action = (roll < 40) ? fpt_pkg::ACT_MAP : fpt_pkg::ACT_UNMAP;
                sz  = $urandom_range(99);
                cnt = (sz < 60) ? $urandom_range(4) :
                      (sz < 95) ? $urandom_range(32, 5) :
                      (sz < 99) ? $urandom_range(256, 33) : $urandom_range(4096, 1024);
                if ($urandom_range(3) == 0) r.va = r.va + $urandom_range(PAGE_SIZE - 1);
                r.len = 32'((cnt << fpt_pkg::PAGE_BITS) +
                            (($urandom_range(3) == 0) ? $urandom_range(PAGE_SIZE - 1) : 0));
            end else if (roll < 95) begin
                r.action = fpt_pkg::ACT_XLATE;
                r.va     = r.va + $urandom_range(PAGE_SIZE - 1);
            end else begin
                r.action = ACT_SPARE;
                r.va     = $urandom;
                r.len    = $urandom;
            end
            req_fifo.push_back(r);
        end
    endtask

    task automatic run_random(logic [31:0] lo, logic [31:0] hi, int send_pct,
                              int recv_pct, logic pressure);
        set_window(lo, hi, 1'b1);
        @(negedge i_clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        if (pressure) hold_armed <= 1'b1;
        queue_random(RANDOM_PER_RUN);
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No device: map refused, unmap and translate still served
        set_window(32'd0, fpt_pkg::WIN_END_RESET, 1'b0);
        @(negedge i_clk);
        queue_req(fpt_pkg::ACT_MAP,   32'h0000_0000, 32'h0000_1000, 32'h0000_1000);
        queue_req(fpt_pkg::ACT_UNMAP, 32'h0000_0000, 32'h0000_0000, 32'h0000_2000);
        queue_req(fpt_pkg::ACT_XLATE, 32'h0000_1234, 32'h0000_0000, 32'h0000_0000);
        queue_req(ACT_SPARE,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(fpt_pkg::ACT_XLATE, 32'h1000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_req(fpt_pkg::ACT_UNMAP, 32'h0FFF_F000, 32'h0000_0000, 32'h0000_2000);
        drain();

        // Device attached: full-table map with page number wrap, then further maps, an unmap and spot reads
        write_reg(fpt_pkg::CFG_ATTACHED, 32'd1);
        @(negedge i_clk);
        queue_req(fpt_pkg::ACT_MAP,   32'h0000_0000, 32'hFFFF_F000, 32'h1000_0000);
        queue_req(fpt_pkg::ACT_XLATE, 32'h0FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        queue_req(fpt_pkg::ACT_XLATE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_req(fpt_pkg::ACT_MAP,   32'h0000_5000, 32'h0000_0000, 32'h0000_0FFF);
        queue_req(fpt_pkg::ACT_MAP,   32'h0000_0000, 32'h1234_5000, 32'hFFFF_FFFF);
        queue_req(fpt_pkg::ACT_UNMAP, 32'h0000_1000, 32'h0000_0000, 32'h0000_3000);
        queue_req(fpt_pkg::ACT_XLATE, 32'h0000_2ABC, 32'h0000_0000, 32'h0000_0000);
        queue_req(fpt_pkg::ACT_XLATE, 32'h0000_4FFF, 32'h0000_0000, 32'h0000_0000);
        drain();

        // One-byte window at the very top of the address space
        set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        @(negedge i_clk);
        queue_req(fpt_pkg::ACT_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        queue_req(fpt_pkg::ACT_MAP,   32'hFFFF_FFFF, 32'hABCD_E000, 32'h0000_0001);
        queue_req(fpt_pkg::ACT_MAP,   32'hFFFF_FFFF, 32'hABCD_E000, 32'h0000_1000);
        queue_req(fpt_pkg::ACT_XLATE, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000);
        drain();

        // Inverted window: everything out of range
        set_window(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        @(negedge i_clk);
        queue_req(fpt_pkg::ACT_MAP,   32'h8000_0000, 32'h0000_0000, 32'h0000_1000);
        queue_req(fpt_pkg::ACT_UNMAP, 32'h8000_0000, 32'h0000_0000, 32'h0000_1000);
        queue_req(fpt_pkg::ACT_XLATE, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        drain();

        // Window larger than the table: runs past the last entry
        set_window(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        @(negedge i_clk);
        queue_req(fpt_pkg::ACT_XLATE, 32'h1000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_req(fpt_pkg::ACT_MAP,   32'h0FFF_F000, 32'h0000_0000, 32'h0000_2000);
        queue_req(fpt_pkg::ACT_UNMAP, 32'h0FFF_F000, 32'h0000_0000, 32'h0000_1000);
        queue_req(fpt_pkg::ACT_UNMAP, 32'h0000_0000, 32'h0000_0000, 32'h1000_0000);
        queue_req(fpt_pkg::ACT_XLATE, 32'h0FFF_FABC, 32'h0000_0000, 32'h0000_0000);
        drain();

        // Random runs under each idling pattern, each with its own window
        run_random(32'h0000_0000, fpt_pkg::WIN_END_RESET, 0,  0,  1'b1);
        run_random(32'h8000_0800, 32'h8020_07FF, 48, 0,  1'b0);
        run_random(32'hFFE0_0000, 32'hFFFF_FFFF, 0,  48, 1'b0);
        run_random(32'h1000_0000, 32'hFFFF_FFFF, 35, 35, 1'b0);

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fpt_pkg.sv
hw/rtl/fpt_dp.sv
hw/rtl/fpt_ctrl.sv
hw/rtl/flat_page_table_iommu_top.sv
tb/sv/flat_page_table_iommu_top_test.sv
